/* sv/ont_pkg.sv */
// shared types and constants of the ordered name table
package ont_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned PosW       = 6;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpDelete = 2'd1,
    OpSearch = 2'd2,
    OpList   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StAdded    = 3'd0,
    StFull     = 3'd1,
    StExists   = 3'd2,
    StDeleted  = 3'd3,
    StNotFound = 3'd4,
    StFound    = 3'd5,
    StEmpty    = 3'd6,
    StEntry    = 3'd7
  } status_e;

  typedef struct packed {
    op_e             op;
    logic [KeyW-1:0] name_key;
  } in_word_t;

  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] position;
    logic [KeyW-1:0] entry_key;
    logic            last;
  } out_word_t;

  // per-cell update command, at most one field is set
  typedef struct packed {
    logic load_new;
    logic take_next;
    logic take_wrap;
  } cell_ctrl_t;

endpackage

/* sv/ont_cell.sv */
// one table cell: a stored key, its update mux and its key comparator
module ont_cell (
  input  logic                    clk_i,
  input  ont_pkg::cell_ctrl_t     ctrl_i,
  input  logic [ont_pkg::KeyW-1:0] probe_i,
  input  logic [ont_pkg::KeyW-1:0] new_key_i,
  input  logic [ont_pkg::KeyW-1:0] next_key_i,
  input  logic [ont_pkg::KeyW-1:0] wrap_key_i,
  output logic [ont_pkg::KeyW-1:0] key_o,
  output logic                    match_o
);

  logic [ont_pkg::KeyW-1:0] key_q, key_d;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.load_new) begin
      key_d = new_key_i;
    end else if (ctrl_i.take_wrap) begin
      key_d = wrap_key_i;
    end else if (ctrl_i.take_next) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign match_o = (key_q == probe_i);

endmodule

/* sv/ordered_name_table_top.sv */
// ordered name table: top level with control, result register and the row of cells
//
// A compact ordered table of unique 64-bit name keys, one key per cell in a row of
// TableDepth cells, plus an entry count. For add, delete and search the name is
// compared against every cell in the accept cycle; in the match state, once the
// output slot is free, the block reports the result and updates the row (an add
// writes the cell at the count, a delete shifts every cell above the hit down by
// one neighbor). List rotates the row toward cell 0 once per word and leaves the
// table as it found it; an empty table gives a single empty word. A new word is
// taken only when the previous one has finished its work; the output register
// lets it be taken while the last result still waits, and a result that cannot
// leave stalls the work behind it. No clearing pass after reset.
module ordered_name_table_top #(
  parameter int unsigned TableDepth = ont_pkg::TableDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ont_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ont_pkg::out_word_t out_word_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TableDepth);

  typedef enum logic [2:0] {
    SIdle  = 3'b001,
    SMatch = 3'b010,
    SList  = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  ont_pkg::op_e              op_q;
  logic [ont_pkg::KeyW-1:0]  key_q;
  logic [TableDepth-1:0]     match_q, match_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  ont_pkg::out_word_t        out_word_q, out_word_d;

  logic [ont_pkg::KeyW-1:0]  cell_key [TableDepth];
  logic [ont_pkg::KeyW-1:0]  next_key [TableDepth];
  logic [TableDepth-1:0]     cell_match;
  ont_pkg::cell_ctrl_t       cell_ctrl [TableDepth];

  logic            accept, slot_free, load_out;
  logic            do_commit, do_add, do_del, do_rot;
  logic            hit, full;
  logic [IdxW-1:0] hit_idx;
  logic [CntW-1:0] count_last;

  assign in_ready_o = (state_q == SIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign full       = (count_q == DepthCnt);
  assign count_last = count_q - CntW'(1);
  assign hit        = |match_q;

  // keys are unique among valid cells, so at most one match bit is set
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TableDepth; i++) begin
      if (match_q[i]) begin
        hit_idx = hit_idx | IdxW'(i);
      end
    end
  end

  assign do_commit = (state_q == SMatch) && slot_free;
  assign do_add    = do_commit && (op_q == ont_pkg::OpAdd) && !full && !hit;
  assign do_del    = do_commit && (op_q == ont_pkg::OpDelete) && hit;
  assign do_rot    = (state_q == SList) && slot_free;

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    if (i == TableDepth - 1) begin : g_end
      assign next_key[i] = cell_key[i];
    end else begin : g_mid
      assign next_key[i] = cell_key[i+1];
    end

    always_comb begin
      cell_ctrl[i].load_new  = do_add && (count_q == CntW'(i));
      cell_ctrl[i].take_wrap = do_rot && (count_last == CntW'(i));
      cell_ctrl[i].take_next = (do_del && (IdxW'(i) >= hit_idx))
                            || (do_rot && (CntW'(i) < count_last));
      match_d[i] = cell_match[i] && (CntW'(i) < count_q);
    end

    ont_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[i]),
      .probe_i    (in_word_i.name_key),
      .new_key_i  (key_q),
      .next_key_i (next_key[i]),
      .wrap_key_i (cell_key[0]),
      .key_o      (cell_key[i]),
      .match_o    (cell_match[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    load_out    = 1'b0;
    out_word_d  = out_word_q;

    case (state_q)
      SIdle: begin
        if (accept) begin
          idx_d = '0;
          if ((in_word_i.op == ont_pkg::OpList) && (count_q != '0)) begin
            state_d = SList;
          end else begin
            state_d = SMatch;
          end
        end
      end
      SMatch: begin
        if (slot_free) begin
          load_out              = 1'b1;
          state_d               = SIdle;
          out_word_d.entry_key  = '0;
          out_word_d.last       = 1'b1;
          out_word_d.position   = '0;
          case (op_q)
            ont_pkg::OpAdd: begin
              if (full) begin
                out_word_d.status = ont_pkg::StFull;
              end else if (hit) begin
                out_word_d.status   = ont_pkg::StExists;
                out_word_d.position = ont_pkg::PosW'(hit_idx);
              end else begin
                out_word_d.status   = ont_pkg::StAdded;
                out_word_d.position = ont_pkg::PosW'(count_q);
                count_d             = count_q + CntW'(1);
              end
            end
            ont_pkg::OpDelete: begin
              if (hit) begin
                out_word_d.status   = ont_pkg::StDeleted;
                out_word_d.position = ont_pkg::PosW'(hit_idx);
                count_d             = count_last;
              end else begin
                out_word_d.status = ont_pkg::StNotFound;
              end
            end
            ont_pkg::OpSearch: begin
              if (hit) begin
                out_word_d.status   = ont_pkg::StFound;
                out_word_d.position = ont_pkg::PosW'(hit_idx);
              end else begin
                out_word_d.status = ont_pkg::StNotFound;
              end
            end
            default: begin
              out_word_d.status = ont_pkg::StEmpty;
            end
          endcase
        end
      end
      SList: begin
        if (slot_free) begin
          load_out             = 1'b1;
          out_word_d.status    = ont_pkg::StEntry;
          out_word_d.position  = ont_pkg::PosW'(idx_q);
          out_word_d.entry_key = cell_key[0];
          out_word_d.last      = (CntW'(idx_q) == count_last);
          idx_d                = idx_q + IdxW'(1);
          if (CntW'(idx_q) == count_last) begin
            state_d = SIdle;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_word_i.op;
      key_q   <= in_word_i.name_key;
      match_q <= match_d;
    end
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("entry count above table depth");

  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SList) |-> (count_q != '0))
    else $error("list walk on an empty table");

  a_entry_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status == ont_pkg::StEntry))
      |-> (CntW'(out_word_o.position) < count_q))
    else $error("list word position beyond entry count");

  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status != ont_pkg::StEntry))
      |-> (out_word_o.entry_key == '0))
    else $error("nonzero key on a status word");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_add |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("add did not grow the table");

endmodule
